/* rtl/tws_pkg.sv */
// ============================================================================
// tws_pkg
// Shared types and constants for the task watchdog supervisor.
// ============================================================================
package tws_pkg;

   // Request kinds carried on the request channel.
   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_REGISTER = 2'd1,
      REQ_ALIVE    = 2'd2,
      REQ_CHECK    = 2'd3
   } req_kind_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_IGNORED = 2'd2,
      ST_HALTED  = 2'd3
   } status_type;

   localparam int unsigned TIME_W        = 32;
   localparam int unsigned HANDLE_W      = 8;
   localparam int unsigned CHECK_DIVISOR = 4;
   // The check window is the timeout divided by the check divisor (a power of two).
   localparam int unsigned CHECK_SHIFT   = $clog2(CHECK_DIVISOR);
   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd1000;

endpackage

/* rtl/task_watchdog_supervisor_top.sv */
// ============================================================================
// task_watchdog_supervisor_top
// Watchdog supervisor for a small set of task slots with a millisecond clock.
// ============================================================================
//
// The supervisor keeps a wrapping 32-bit millisecond counter and SLOTS task
// slots, each with an in-use flag and a last-seen time stamp held in a small
// RAM. Every request transfer produces exactly one response transfer. A tick
// advances the counter, a register request claims the lowest free slot and
// returns its handle, an alive request restamps an active slot, and a check
// request raises feed when every active slot has been seen within a quarter
// of the programmed timeout (ages wrap modulo 2^32). A register request that
// finds every slot taken halts the block for good; from then on every request
// is answered with the halted status and no state changes. The block works on
// one request at a time: ticks, alive reports and requests seen while halted
// go from idle straight to the done state, which loads the response into the
// output register once it is free; a register request steps up from the
// lowest slot to the first free one; a check walks the slots with one
// shared subtract and compare unit, skips idle slots, reads an active slot's
// stamp from the registered RAM before comparing it, and stops at a stale slot.
// A new request is taken as soon as the sequencer is back in idle, even while
// the previous response still waits in the output register. The timeout
// register may be written at any time the block is idle; it is sampled when a
// check compares ages.
//
module task_watchdog_supervisor_top
   import tws_pkg::*;
#(
   parameter int unsigned SLOTS = 4
) (
   input  logic                clock,
   input  logic                reset,
   // Request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic [HANDLE_W-1:0] req_handle,
   // Response channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [1:0]          rsp_slot_given,
   output logic                rsp_feed,
   // Configuration: timeout in milliseconds
   input  logic                csr_wr_en,
   input  logic [TIME_W-1:0]   csr_wr_data
);

   localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SLOT_W-1:0]   LAST_SLOT    = SLOT_W'(SLOTS - 1);
   localparam logic [HANDLE_W-1:0] HANDLE_LIMIT = HANDLE_W'(SLOTS);

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_REG,
      S_SCAN_CHK,
      S_CHK_CMP,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [TIME_W-1:0]   timeout_ff, timeout_in;
   logic                halted_ff, halted_in;
   logic [SLOTS-1:0]    in_use_ff, in_use_in;

   // Result being built for the current request.
   status_type          res_status_ff, res_status_in;
   logic [1:0]          res_given_ff, res_given_in;
   logic                res_feed_ff, res_feed_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [1:0]          rsp_given_ff, rsp_given_in;
   logic                rsp_feed_ff, rsp_feed_in;

   // Time stamp RAM controls.
   logic                ram_wr_en;
   logic [SLOT_W-1:0]   ram_wr_addr;
   logic                ram_rd_en;
   logic [TIME_W-1:0]   ram_rd_data;

   // Shared age unit: wrapped age of the slot just read against the window.
   logic [TIME_W-1:0]   window;
   logic [TIME_W-1:0]   age;
   logic                stale;

   logic                req_fire;
   logic [SLOT_W-1:0]   handle_idx;
   logic                handle_ok;

   assign window     = timeout_ff >> CHECK_SHIFT;
   assign age        = now_ff - ram_rd_data;
   assign stale      = age > window;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign handle_idx = req_handle[SLOT_W-1:0];
   assign handle_ok  = (req_handle < HANDLE_LIMIT) && in_use_ff[handle_idx];

   tws_ram #(
      .WIDTH (TIME_W),
      .DEPTH (SLOTS)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (now_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      now_in        = now_ff;
      timeout_in    = timeout_ff;
      halted_in     = halted_ff;
      in_use_in     = in_use_ff;
      res_status_in = res_status_ff;
      res_given_in  = res_given_ff;
      res_feed_in   = res_feed_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_given_in  = rsp_given_ff;
      rsp_feed_in   = rsp_feed_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_rd_en     = 1'b0;

      if (csr_wr_en) begin
         timeout_in = csr_wr_data;
      end

      // A taken response frees the output register.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_status_in = ST_OK;
               res_given_in  = 2'd0;
               res_feed_in   = 1'b0;
               idx_in        = '0;
               state_in      = S_DONE;
               if (halted_ff) begin
                  res_status_in = ST_HALTED;
               end else begin
                  unique case (req_kind_type'(req_type))
                     REQ_TICK: begin
                        now_in = now_ff + 32'd1;
                     end
                     REQ_REGISTER: begin
                        state_in = S_SCAN_REG;
                     end
                     REQ_ALIVE: begin
                        if (handle_ok) begin
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = handle_idx;
                        end else begin
                           res_status_in = ST_IGNORED;
                        end
                     end
                     REQ_CHECK: begin
                        // Feed holds unless some active slot turns out stale.
                        res_feed_in = 1'b1;
                        state_in    = S_SCAN_CHK;
                     end
                     default: begin
                        state_in = S_DONE;
                     end
                  endcase
               end
            end
         end

         S_SCAN_REG: begin
            if (!in_use_ff[idx_ff]) begin
               in_use_in[idx_ff] = 1'b1;
               ram_wr_en         = 1'b1;
               res_given_in      = 2'(idx_ff);
               state_in          = S_DONE;
            end else if (idx_ff == LAST_SLOT) begin
               res_status_in = ST_FULL;
               halted_in     = 1'b1;
               state_in      = S_DONE;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end

         S_SCAN_CHK: begin
            if (in_use_ff[idx_ff]) begin
               ram_rd_en = 1'b1;
               state_in  = S_CHK_CMP;
            end else if (idx_ff == LAST_SLOT) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end

         S_CHK_CMP: begin
            if (stale) begin
               res_feed_in = 1'b0;
               state_in    = S_DONE;
            end else if (idx_ff == LAST_SLOT) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = S_SCAN_CHK;
            end
         end

         S_DONE: begin
            // Move the finished result into the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_given_in  = res_given_ff;
               rsp_feed_in   = res_feed_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         now_ff       <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         halted_ff    <= 1'b0;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         now_ff        <= now_in;
         timeout_ff    <= timeout_in;
         halted_ff     <= halted_in;
         in_use_ff     <= in_use_in;
         res_status_ff <= res_status_in;
         res_given_ff  <= res_given_in;
         res_feed_ff   <= res_feed_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_given_ff  <= rsp_given_in;
         rsp_feed_ff   <= rsp_feed_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_given = rsp_given_ff;
   assign rsp_feed       = rsp_feed_ff;

endmodule

/* rtl/tws_ram.sv */
// ============================================================================
// tws_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module tws_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/sv/tb_task_watchdog_supervisor_top.sv */
// ----------------------------------------------------------------------------
// Task watchdog supervisor testbench
// Drives request, response and timeout register traffic into the supervisor.
// A scoreboard class tracks the slot table, the millisecond clock and the
// halted flag, and checks every response against its own prediction.
// ----------------------------------------------------------------------------
module tb_task_watchdog_supervisor_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tws_pkg::*;

   localparam int unsigned SLOTS       = 4;
   localparam int          PHASES      = 6;
   localparam int          PHASE_ITEMS = 195;
   localparam int          MAX_GAP     = 40;
   localparam int          HOLD_CYCLES = 80;
   localparam int          QUIET_LIMIT = 2000;
   localparam int          TAIL_CYCLES = 20;

   // One response as the supervisor should return it.
   typedef struct {
      status_type status;
      logic [1:0] slot_given;
      logic       feed;
   } slot_rsp_type;

   // ------------------------------------------------------------------------
   // Scoreboard. It keeps its own copy of the slot table and the clock, works
   // out the response of every accepted request, and compares responses with
   // the oldest outstanding prediction.
   // ------------------------------------------------------------------------
   class watchdog_scoreboard;
      logic [TIME_W-1:0] timeout_val;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] last_seen[SLOTS];
      bit                in_use[SLOTS];
      bit                halted;
      slot_rsp_type      awaited_rsp[$];
      int                errors;
      int                n_requests;
      int                n_fed;
      int                n_stale;
      int                n_ignored;
      int                n_halted;

      function new();
         timeout_val = TIMEOUT_RESET;
         now_ms      = '0;
         for (int i = 0; i < SLOTS; i++) begin
            last_seen[i] = '0;
            in_use[i]    = 1'b0;
         end
         halted     = 1'b0;
         errors     = 0;
         n_requests = 0;
         n_fed      = 0;
         n_stale    = 0;
         n_ignored  = 0;
         n_halted   = 0;
      endfunction

      function void set_timeout(logic [TIME_W-1:0] value);
         timeout_val = value;
      endfunction

      function int pending();
         return awaited_rsp.size();
      endfunction

      // Applies one accepted request to the slot table and queues its response.
      function void note_request(req_kind_type kind, logic [HANDLE_W-1:0] h);
         slot_rsp_type      r;
         logic [TIME_W-1:0] window;
         bit                found;
         r.status     = ST_OK;
         r.slot_given = 2'd0;
         r.feed       = 1'b0;
         n_requests++;
         if (halted) begin
            r.status = ST_HALTED;
            n_halted++;
         end else begin
            case (kind)
               REQ_TICK: begin
                  now_ms = now_ms + 1;
               end
               REQ_REGISTER: begin
                  found = 1'b0;
                  for (int i = 0; i < SLOTS; i++) begin
                     if (!found && !in_use[i]) begin
                        in_use[i]    = 1'b1;
                        last_seen[i] = now_ms;
                        r.slot_given = i[1:0];
                        found        = 1'b1;
                     end
                  end
                  if (!found) begin
                     r.status = ST_FULL;
                     halted   = 1'b1;
                  end
               end
               REQ_ALIVE: begin
                  if (h < SLOTS && in_use[h]) begin
                     last_seen[h] = now_ms;
                  end else begin
                     r.status = ST_IGNORED;
                     n_ignored++;
                  end
               end
               default: begin
                  // Ages wrap modulo 2^32 since both operands are 32 bits wide.
                  window = timeout_val / CHECK_DIVISOR;
                  r.feed = 1'b1;
                  for (int i = 0; i < SLOTS; i++) begin
                     if (in_use[i] && (now_ms - last_seen[i]) > window) r.feed = 1'b0;
                  end
                  if (r.feed) n_fed++;
                  else n_stale++;
               end
            endcase
         end
         awaited_rsp.push_back(r);
      endfunction

      function void check_response(logic [1:0] status, logic [1:0] slot_given, logic feed);
         slot_rsp_type want;
         if (awaited_rsp.size() == 0) begin
            errors++;
            $display("%0d ns: response with none outstanding, status %0d slot %0d feed %0d",
                     $time, status, slot_given, feed);
            return;
         end
         want = awaited_rsp.pop_front();
         if (status !== want.status) begin
            errors++;
            $display("%0d ns: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
         end
         if (slot_given !== want.slot_given) begin
            errors++;
            $display("%0d ns: slot_given mismatch, expected %0d, actual %0d",
                     $time, want.slot_given, slot_given);
         end
         if (feed !== want.feed) begin
            errors++;
            $display("%0d ns: feed mismatch, expected %0d, actual %0d",
                     $time, want.feed, feed);
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // Signals. Every input of the block starts at a known value.
   // ------------------------------------------------------------------------
   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   logic [1:0]          req_type    = REQ_TICK;
   logic [HANDLE_W-1:0] req_handle  = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   logic [1:0]          rsp_status;
   logic [1:0]          rsp_slot_given;
   logic                rsp_feed;
   logic                csr_wr_en   = 1'b0;
   logic [TIME_W-1:0]   csr_wr_data = '0;

   watchdog_scoreboard sb;

   // Idle percentages of the two sides; the main sequence changes them per phase.
   int send_idle_pct   = 0;
   int rsp_idle_pct    = 0;
   // The main sequence bumps holds_requested; the receiver notices the
   // difference and then keeps rsp_ready low for a long counted stretch.
   int holds_requested = 0;
   int holds_done      = 0;
   int hold_left       = 0;
   int regs_issued     = 0;
   int quiet_cycles    = 0;

   task_watchdog_supervisor_top #(
      .SLOTS(SLOTS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_handle     (req_handle),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_slot_given (rsp_slot_given),
      .rsp_feed       (rsp_feed),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Response side. A transfer is taken at an edge where rsp_valid and
   // rsp_ready were both high; the outputs read here still hold the values
   // from before the edge because the block updates them through its flops.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_status, rsp_slot_given, rsp_feed);
      end
      if (holds_done != holds_requested) begin
         holds_done++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Ends the run when neither channel has seen a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0d ns: no transfer for %0d cycles, %0d responses outstanding",
                  $time, QUIET_LIMIT, sb.pending());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------------

   // Offers one request and returns after the edge at which it was accepted.
   // The valid stays high afterwards, so a following request can reuse it
   // without a drop; callers that pause lower it first.
   task automatic send_request(input req_kind_type kind, input logic [HANDLE_W-1:0] h);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_type   <= kind;
      req_handle <= h;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, h);
      if (kind == REQ_REGISTER) regs_issued++;
   endtask

   // Stops offering and waits until every predicted response has come back,
   // which leaves the block idle.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic program_timeout(input logic [TIME_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_timeout(value);
   endtask

   // Random traffic. Ticks, alive reports and checks dominate so that ages
   // move around the check window; registrations stop once every slot is
   // taken, because one more would halt the block for the rest of the run.
   task automatic send_random_items(input int count);
      int                  sent;
      int                  r;
      int                  burst;
      req_kind_type        kind;
      logic [HANDLE_W-1:0] h;
      sent = 0;
      while (sent < count) begin
         r = $urandom_range(99);
         h = HANDLE_W'($urandom_range(255));
         if (r < 4) begin
            // A run of ticks lets slots go stale against wider windows.
            burst = $urandom_range(15, 3);
            repeat (burst) send_request(REQ_TICK, HANDLE_W'($urandom_range(255)));
            sent += burst;
         end else begin
            if (r < 40) begin
               kind = REQ_TICK;
            end else if (r < 68) begin
               kind = REQ_ALIVE;
               // Mostly real handles, sometimes anything up to 255.
               if ($urandom_range(9) < 8) h = HANDLE_W'($urandom_range(SLOTS - 1));
            end else if (r < 94 || regs_issued >= SLOTS) begin
               kind = REQ_CHECK;
            end else begin
               kind = REQ_REGISTER;
            end
            send_request(kind, h);
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      logic [TIME_W-1:0] tmo;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first under the timeout value left by reset.
      send_idle_pct = 29;
      rsp_idle_pct  = 88;
      send_request(REQ_CHECK, 8'h00);     // no slot active yet, so feed is high
      send_request(REQ_ALIVE, 8'h00);     // slot exists but is not in use
      send_request(REQ_ALIVE, 8'hFF);     // handle far beyond the slot count
      send_request(REQ_REGISTER, 8'hAA);  // takes slot 0; the handle is unused
      send_request(REQ_TICK, 8'h55);
      send_request(REQ_CHECK, 8'h00);     // age 1 against a window of 250

      // A tiny window of two milliseconds makes stale slots easy to reach.
      wait_for_responses();
      program_timeout(32'd8);
      send_request(REQ_TICK, 8'h00);
      send_request(REQ_TICK, 8'h00);
      send_request(REQ_TICK, 8'h00);
      send_request(REQ_CHECK, 8'h00);     // slot 0 is stale
      send_request(REQ_ALIVE, 8'h00);
      send_request(REQ_CHECK, 8'h00);     // fresh again
      send_request(REQ_REGISTER, 8'h00);  // takes slot 1
      send_request(REQ_ALIVE, 8'h01);
      send_request(REQ_ALIVE, 8'h02);     // in range but not in use
      send_request(REQ_ALIVE, 8'h04);     // first handle at the slot count
      send_request(REQ_ALIVE, 8'h80);
      send_request(REQ_TICK, 8'hFF);
      send_request(REQ_TICK, 8'h7F);
      send_request(REQ_CHECK, 8'hFF);     // age exactly equal to the window
      send_request(REQ_TICK, 8'h00);
      send_request(REQ_CHECK, 8'h00);     // one past the window

      // Random phases, each with its own timeout and idling pattern. The
      // phases without idling also get a long receiver hold so the block
      // fills up and has to stall its request side.
      for (int p = 0; p < PHASES; p++) begin
         wait_for_responses();
         case (p)
            0:       tmo = 32'd0;
            1, 3:    tmo = TIME_W'($urandom_range(80, 4));
            2:       tmo = 32'hFFFF_FFFF;
            4:       tmo = 32'd3;
            default: tmo = TIMEOUT_RESET;
         endcase
         program_timeout(tmo);
         case (p % 3)
            0: begin
               send_idle_pct = 29;
               rsp_idle_pct  = 88;
            end
            1: begin
               send_idle_pct = 88;
               rsp_idle_pct  = 29;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
               holds_requested++;
            end
         endcase
         send_random_items(PHASE_ITEMS);
      end

      // Fill the remaining slots, overflow the table, and then show that
      // every kind of request is answered as halted.
      send_idle_pct = 29;
      rsp_idle_pct  = 29;
      while (regs_issued <= SLOTS) send_request(REQ_REGISTER, HANDLE_W'($urandom_range(255)));
      repeat (16) begin
         send_request(req_kind_type'($urandom_range(3)), HANDLE_W'($urandom_range(255)));
      end

      wait_for_responses();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d checks fed, %0d checks stale, %0d alive reports ignored,",
               sb.n_requests, sb.n_fed, sb.n_stale, sb.n_ignored);
      $display("timeouts from 0 to the 32-bit maximum, slot overflow and %0d halted answers.",
               sb.n_halted);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
